>>> src/srt_pkg.sv
// Shared types and codes for the stack region table.
package srt_pkg;

  typedef enum logic [2:0] {
    CMD_ALLOC    = 3'd0,
    CMD_REGISTER = 3'd1,
    CMD_FREE     = 3'd2,
    CMD_OWNER    = 3'd3,
    CMD_LOOKUP   = 3'd4,
    CMD_CHECK    = 3'd5
  } cmd_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SLOT   = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic [2:0] REG_AREA_TOP    = 3'd0;
  localparam logic [2:0] REG_AREA_BOTTOM = 3'd1;
  localparam logic [2:0] REG_ACTIVE      = 3'd2;
  localparam logic [2:0] REG_MIN_SIZE    = 3'd3;
  localparam logic [2:0] REG_MAX_SIZE    = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] address;
    logic [31:0] size;
    logic [31:0] thread_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] region_base;
    logic [31:0] region_limit;
    logic        found;
    logic        user_placed;
    logic [31:0] owner_tid;
    logic        inside_stack;
    logic        valid_pointer;
    logic [4:0]  live_count;
  } rsp_t;

endpackage

>>> src/srt_front.sv
// Front end: takes command words, pre-rounds the size and queues them.
module srt_front import srt_pkg::*; #(
  parameter int PAGE_SHIFT = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  req_t        req,
  output logic        q_valid,
  input  logic        q_take,
  output req_t        q_req,
  output logic [31:0] q_rsize
);
  localparam logic [31:0] PageMask = (32'd1 << PAGE_SHIFT) - 32'd1;

  req_t        buf_req [2];
  logic [31:0] buf_rs  [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  fill;

  assign full    = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_req   = buf_req[rd_ptr];
  assign q_rsize = buf_rs[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) begin
        buf_req[wr_ptr] <= req;
        buf_rs[wr_ptr]  <= (req.size + PageMask) & ~PageMask;
        wr_ptr          <= ~wr_ptr;
      end
      if (q_take && q_valid) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push && !full) - 2'(q_take && q_valid);
    end
  end
endmodule

>>> src/srt_back.sv
// Back end: scans the slot table one entry a cycle and executes commands.
module srt_back import srt_pkg::*; #(
  parameter int MAX_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        q_valid,
  output logic        q_take,
  input  req_t        q_req,
  input  logic [31:0] q_rsize,
  output logic        empty,
  input  logic        pop,
  output rsp_t        rsp
);
  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC, S_OUT} state_t;

  logic [31:0] area_top, area_bottom, min_size, max_size, bump_pointer;
  logic [4:0]  active_slots;
  logic [31:0] slot_base  [MAX_SLOTS];
  logic [31:0] slot_limit [MAX_SLOTS];
  logic [31:0] slot_owner [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] slot_live, slot_user;
  logic [CW-1:0] region_count;

  state_t      state;
  req_t        cur;
  logic [31:0] rsize, sz;
  logic [IW:0] idx;
  logic [IW:0] scan_n;
  logic        have_free, have_hit, clash, in_region;
  logic [IW-1:0] free_i, hit_i;
  logic        out_valid;
  rsp_t        out_rsp;
  rsp_t        out_next;
  logic [31:0] nl_reg;
  logic [31:0] alloc_nl;
  logic        alloc_ok, reg_ok;

  assign scan_n = ({1'b0, active_slots} < (MAX_SLOTS))
                ? (IW+1)'(active_slots) : (IW+1)'(MAX_SLOTS);
  assign empty  = !out_valid;
  assign rsp    = out_rsp;
  assign q_take = (state == S_IDLE) && q_valid && !out_valid;

  logic [IW-1:0] ci;
  logic [31:0]   cb, cl;
  logic          clv;
  assign ci  = idx[IW-1:0];
  assign cb  = slot_base[ci];
  assign cl  = slot_limit[ci];
  assign clv = slot_live[ci];

  // space check for allocate: the new limit must not drop below the window or wrap
  assign alloc_nl = bump_pointer - sz;
  assign alloc_ok = have_free && (alloc_nl >= area_bottom) && (alloc_nl <= bump_pointer);
  assign reg_ok   = have_free && !(cur.address > area_top || nl_reg < area_bottom || clash);

  always_comb begin
    out_next = '0;
    out_next.live_count = 5'(region_count);
    case (cur.command)
      CMD_ALLOC: begin
        if (!have_free) out_next.status = ST_NO_SLOT;
        else if (!alloc_ok) out_next.status = ST_NO_SPACE;
        else begin
          out_next.live_count   = 5'(region_count + 1'b1);
          out_next.region_base  = bump_pointer;
          out_next.region_limit = alloc_nl;
        end
      end
      CMD_REGISTER: begin
        if (!have_free) out_next.status = ST_NO_SLOT;
        else if (!reg_ok) out_next.status = ST_BAD_ADDR;
        else begin
          out_next.live_count   = 5'(region_count + 1'b1);
          out_next.region_base  = cur.address;
          out_next.region_limit = nl_reg;
        end
      end
      CMD_FREE: begin
        if (!have_hit) out_next.status = ST_NOT_FOUND;
        else out_next.live_count = 5'(region_count - 1'b1);
      end
      CMD_OWNER: begin
        if (!have_hit) out_next.status = ST_NOT_FOUND;
        else out_next.found = 1'b1;
      end
      CMD_LOOKUP: begin
        if (!have_hit) out_next.status = ST_NOT_FOUND;
        else begin
          out_next.region_base  = slot_base[hit_i];
          out_next.region_limit = slot_limit[hit_i];
          out_next.found        = 1'b1;
          out_next.user_placed  = slot_user[hit_i];
          out_next.owner_tid    = slot_owner[hit_i];
        end
      end
      CMD_CHECK: begin
        out_next.inside_stack  = in_region;
        out_next.valid_pointer = cur.address >= area_bottom &&
          cur.address <= area_top && cur.address[1:0] == 2'b00;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area_top <= '0; area_bottom <= '0; active_slots <= 5'd16;
      min_size <= 32'd4096; max_size <= 32'd65536; bump_pointer <= '0;
      slot_live <= '0; slot_user <= '0; region_count <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) slot_owner[i] <= '0;
      state <= S_IDLE; out_valid <= 1'b0;
    end else begin
      if (out_valid && pop) out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_AREA_TOP:    begin area_top <= cfg_data; bump_pointer <= cfg_data; end
          REG_AREA_BOTTOM: area_bottom <= cfg_data;
          REG_ACTIVE:      active_slots <= cfg_data[4:0];
          REG_MIN_SIZE:    min_size <= cfg_data;
          REG_MAX_SIZE:    max_size <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (q_take) begin
            cur <= q_req; rsize <= q_rsize; idx <= '0;
            have_free <= 1'b0; have_hit <= 1'b0; clash <= 1'b0; in_region <= 1'b0;
            nl_reg <= q_req.address - q_rsize;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // clamp size while the scan runs; max applied last
          sz <= (rsize < min_size ? (min_size > max_size ? max_size : min_size)
                                  : (rsize > max_size ? max_size : rsize));
          if (idx >= scan_n) state <= S_EXEC;
          else begin
            if (!clv && !have_free) begin have_free <= 1'b1; free_i <= ci; end
            if (clv && cb == cur.address && !have_hit) begin
              have_hit <= 1'b1; hit_i <= ci;
            end
            if (clv && cur.address > cl && nl_reg < cb) clash <= 1'b1;
            if (clv && cur.address >= cl && cur.address < cb) in_region <= 1'b1;
            idx <= idx + 1'b1;
          end
        end
        S_EXEC: begin
          out_rsp <= out_next;
          case (cur.command)
            CMD_ALLOC: begin
              if (alloc_ok) begin
                slot_base[free_i] <= bump_pointer;
                slot_limit[free_i] <= alloc_nl;
                slot_live[free_i] <= 1'b1; slot_user[free_i] <= 1'b0;
                slot_owner[free_i] <= '0;
                region_count <= region_count + 1'b1;
                bump_pointer <= alloc_nl;
              end
            end
            CMD_REGISTER: begin
              if (reg_ok) begin
                slot_base[free_i] <= cur.address; slot_limit[free_i] <= nl_reg;
                slot_live[free_i] <= 1'b1; slot_user[free_i] <= 1'b1;
                slot_owner[free_i] <= '0;
                region_count <= region_count + 1'b1;
              end
            end
            CMD_FREE: begin
              if (have_hit) begin
                slot_live[hit_i] <= 1'b0;
                region_count <= region_count - 1'b1;
                if (slot_limit[hit_i] == bump_pointer) bump_pointer <= slot_base[hit_i];
              end
            end
            CMD_OWNER: begin
              if (have_hit) slot_owner[hit_i] <= cur.thread_id;
            end
            default: ;
          endcase
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> src/stack_region_table.sv
// Top level of the stack region table: front queue plus scanning back end.
//
//  channel   | handshake       | word
//  ----------+-----------------+-----------------------------------
//  request   | push / full     | req    (command, address, size, tid)
//  response  | pop / empty     | rsp    (status ... live_count)
//  config    | cfg_we          | cfg_index, cfg_data
//
// The back end takes a word from the front queue when it is idle and its
// output is empty, scans min(active_slots, MAX_SLOTS) slots, then executes
// the command in S_EXEC and publishes the response in S_OUT. The back end
// takes the next word only once the response is popped, so it does not start
// a new command before it is through with the last.
// The front holds two words, so requests are taken while the back scans.
// Reset is synchronous; it empties both sides and clears the table flags.
// A waiting response stalls the back end until it is popped.
module stack_region_table import srt_pkg::*; #(
  parameter int MAX_SLOTS  = 16,
  parameter int PAGE_SHIFT = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  req_t        req,
  output logic        empty,
  input  logic        pop,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic        q_valid, q_take;
  req_t        q_req;
  logic [31:0] q_rsize;

  srt_front #(.PAGE_SHIFT(PAGE_SHIFT)) u_front (
    .clk, .rst, .push, .full, .req,
    .q_valid, .q_take, .q_req, .q_rsize
  );

  srt_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .q_valid, .q_take, .q_req, .q_rsize,
    .empty, .pop, .rsp
  );

  // a request is never pulled from an empty front queue
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid) else $error("take from empty queue");

  // a popped response leaves the output empty the next cycle
  a_pop_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty) |=> empty) else $error("response repeated");

  // live count never exceeds the table size
  a_count: assert property (@(posedge clk) disable iff (rst)
    !empty |-> rsp.live_count <= 5'(MAX_SLOTS)) else $error("bad live count");
endmodule
